// File: rtl/core/two_level_page_table_updater_macros.svh
// Assertion macros for the two-level page table updater.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TWO_LEVEL_PAGE_TABLE_UPDATER_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_UPDATER_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define TLPT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define TLPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tlpt_pkg.sv
// Shared types and constants of the two-level page table updater.
// No dependencies; imported by the top level of the block.
`timescale 1ns / 1ps
`default_nettype none

package tlpt_pkg;

  localparam int ENTRIES_PER_TABLE = 1024;
  localparam int IDX_W             = 10;
  localparam int ENTRY_W           = 32;
  localparam int FRAME_NUM_W       = 20;
  localparam int ATTR_W            = 12;
  localparam int DIR_W             = 8;
  localparam int POOL_W            = 8;

  localparam logic [POOL_W-1:0] POOL_START_RESET = 8'd16;

  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_UNMAP = 1'b1;

  localparam logic [ATTR_W-1:0] ATTR_PRESENT = 12'h001;

endpackage

`default_nettype wire

// File: rtl/core/tlpt_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// No dependencies; used for the frame memory of the page table updater.
`timescale 1ns / 1ps
`default_nettype none

module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/two_level_page_table_updater.sv
// Top level of the two-level page table updater: sequencer, allocator and result register.
// Depends on tlpt_pkg, tlpt_ram and two_level_page_table_updater_macros.svh.
//
//   Channel   Direction  Handshake                 Payload
//   -------   ---------  ------------------------  ------------------------------------------
//   request   in         in_valid_i / in_ready_o   op_i, dir_frame_i, virt_page_i,
//                                                  phys_frame_i, attrs_i
//   result    out        out_valid_o / out_ready_i old_frame_o, table_frame_o,
//                                                  table_allocated_o, out_of_frames_o
//   config    in         cfg_we_i (no wait)        cfg_wdata_i (table_pool_start)
//
// A map, or an unmap under a present directory entry, passes from one acceptance to the next
// through the directory read, the directory decision and update, the page table access
// and the result load. All of them go through the single port of the frame memory, so they
// follow one another. An unmap under an absent directory entry and a map that finds the pool
// exhausted skip the page table access.
// After reset a clearing pass zeroes the frame memory, one entry per cycle, over all
// NUM_FRAMES * 1024 entries (262144 at the default); no request is accepted meanwhile.
// The result register lets a request be taken while the previous result still waits; a
// finished request whose result finds the register still full waits until it drains.
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_table_updater
  import tlpt_pkg::*;
#(
  parameter int NUM_FRAMES = 256
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   cfg_we_i,
  input  wire logic [POOL_W-1:0]      cfg_wdata_i,

  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   op_i,
  input  wire logic [DIR_W-1:0]       dir_frame_i,
  input  wire logic [FRAME_NUM_W-1:0] virt_page_i,
  input  wire logic [FRAME_NUM_W-1:0] phys_frame_i,
  input  wire logic [ATTR_W-1:0]      attrs_i,

  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [FRAME_NUM_W-1:0]      old_frame_o,
  output logic [DIR_W-1:0]            table_frame_o,
  output logic                        table_allocated_o,
  output logic                        out_of_frames_o
);

  // Frame memory geometry. A frame number selects a block of 1024 entries.
  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int ADDR_W  = FRAME_W + IDX_W;
  localparam int DEPTH   = NUM_FRAMES * ENTRIES_PER_TABLE;
  // The allocator must hold NUM_FRAMES itself (exhausted) and any 8-bit pool start.
  localparam int NEXT_MAX = (NUM_FRAMES > 256) ? NUM_FRAMES : 256;
  localparam int NEXT_W   = $clog2(NEXT_MAX + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_TWR,
    S_TRD,
    S_RESULT
  } state_e;

  state_e                   state_q;
  logic [ADDR_W-1:0]        clr_cnt_q;
  logic [NEXT_W-1:0]        next_q;

  // Request captured at acceptance.
  logic                     op_q;
  logic [DIR_W-1:0]         dir_q;
  logic [IDX_W-1:0]         dir_idx_q;
  logic [IDX_W-1:0]         tbl_idx_q;
  logic [FRAME_NUM_W-1:0]   phys_q;
  logic [ATTR_W-1:0]        attrs_q;

  // Result under construction.
  logic [FRAME_NUM_W-1:0]   res_old_q;
  logic [FRAME_NUM_W-1:0]   res_tframe_q;
  logic                     res_alloc_q;
  logic                     res_oof_q;

  // Result register toward the output channel.
  logic                     out_valid_q;
  logic [FRAME_NUM_W-1:0]   out_old_q;
  logic [DIR_W-1:0]         out_tframe_q;
  logic                     out_alloc_q;
  logic                     out_oof_q;

  // Frame memory port.
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_addr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [ENTRY_W-1:0]       ram_rdata;

  logic [FRAME_NUM_W-1:0]   dir_in_ext;
  logic [FRAME_NUM_W-1:0]   dir_q_ext;
  logic                     dir_in_range;
  logic                     tframe_in_range;
  logic                     next_full;
  logic [ENTRY_W-1:0]       dent;
  logic                     dir_present;
  logic                     alloc_take;
  logic                     out_load;

  assign dir_in_ext      = FRAME_NUM_W'(dir_frame_i);
  assign dir_q_ext       = FRAME_NUM_W'(dir_q);
  assign dir_in_range    = 32'(dir_q) < 32'(NUM_FRAMES);
  assign tframe_in_range = 32'(res_tframe_q) < 32'(NUM_FRAMES);
  assign next_full       = 32'(next_q) >= 32'(NUM_FRAMES);

  // A directory frame beyond the memory reads as an empty directory.
  assign dent        = dir_in_range ? ram_rdata : '0;
  assign dir_present = dent[0];
  assign alloc_take  = (state_q == S_DIR) && (op_q == OP_MAP) && !dir_present && !next_full;
  assign out_load    = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);

  assign in_ready_o = (state_q == S_IDLE);

  // Frame memory access per state. Accesses of one request follow each other, so a read
  // never meets a write still in flight and no forwarding is needed.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {dir_q_ext[FRAME_W-1:0], dir_idx_q};
    ram_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt_q;
      end
      S_IDLE: begin
        // Directory read is issued as the request is accepted.
        ram_addr = {dir_in_ext[FRAME_W-1:0], virt_page_i[2*IDX_W-1:IDX_W]};
      end
      S_DIR: begin
        if (op_q == OP_MAP) begin
          ram_addr = {dir_q_ext[FRAME_W-1:0], dir_idx_q};
          if (dir_present) begin
            ram_we    = 1'b1;
            ram_wdata = dent | {{FRAME_NUM_W{1'b0}}, attrs_q | ATTR_PRESENT};
          end else if (!next_full) begin
            ram_we    = dir_in_range;
            ram_wdata = {FRAME_NUM_W'(next_q), attrs_q | ATTR_PRESENT};
          end
        end else begin
          // Unmap: fetch the page table entry named by the directory entry.
          ram_addr = {dent[ENTRY_W-FRAME_NUM_W +: FRAME_W], tbl_idx_q};
        end
      end
      S_TWR: begin
        ram_we    = tframe_in_range;
        ram_addr  = {res_tframe_q[FRAME_W-1:0], tbl_idx_q};
        ram_wdata = {phys_q, attrs_q | ATTR_PRESENT};
      end
      S_TRD: begin
        ram_we    = tframe_in_range;
        ram_addr  = {res_tframe_q[FRAME_W-1:0], tbl_idx_q};
        ram_wdata = '0;
      end
      S_RESULT: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tlpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequencer, allocator and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      next_q       <= NEXT_W'(POOL_START_RESET);
      op_q         <= OP_MAP;
      dir_q        <= '0;
      dir_idx_q    <= '0;
      tbl_idx_q    <= '0;
      phys_q       <= '0;
      attrs_q      <= '0;
      res_old_q    <= '0;
      res_tframe_q <= '0;
      res_alloc_q  <= 1'b0;
      res_oof_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_old_q    <= '0;
      out_tframe_q <= '0;
      out_alloc_q  <= 1'b0;
      out_oof_q    <= 1'b0;
    end else begin
      // The result register refills from a finished request or empties on its transaction.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // A pool start write reloads the allocator; it has the last word over an allocation.
      if (cfg_we_i) begin
        next_q <= NEXT_W'(cfg_wdata_i);
      end else if (alloc_take) begin
        next_q <= next_q + 1'b1;
      end

      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q         <= op_i;
            dir_q        <= dir_frame_i;
            dir_idx_q    <= virt_page_i[2*IDX_W-1:IDX_W];
            tbl_idx_q    <= virt_page_i[IDX_W-1:0];
            phys_q       <= phys_frame_i;
            attrs_q      <= attrs_i;
            res_old_q    <= '0;
            res_tframe_q <= '0;
            res_alloc_q  <= 1'b0;
            res_oof_q    <= 1'b0;
            state_q      <= S_DIR;
          end
        end
        S_DIR: begin
          if (op_q == OP_MAP) begin
            if (dir_present) begin
              res_tframe_q <= dent[ENTRY_W-1:ENTRY_W-FRAME_NUM_W];
              state_q      <= S_TWR;
            end else if (next_full) begin
              // Pool exhausted: nothing is written and the allocator stays put.
              res_oof_q <= 1'b1;
              state_q   <= S_RESULT;
            end else begin
              res_tframe_q <= FRAME_NUM_W'(next_q);
              res_alloc_q  <= 1'b1;
              state_q      <= S_TWR;
            end
          end else begin
            if (dir_present) begin
              res_tframe_q <= dent[ENTRY_W-1:ENTRY_W-FRAME_NUM_W];
              state_q      <= S_TRD;
            end else begin
              state_q <= S_RESULT;
            end
          end
        end
        S_TWR: begin
          state_q <= S_RESULT;
        end
        S_TRD: begin
          // A table frame beyond the memory reads as an empty entry.
          res_old_q <= tframe_in_range ? ram_rdata[ENTRY_W-1:ENTRY_W-FRAME_NUM_W] : '0;
          state_q   <= S_RESULT;
        end
        S_RESULT: begin
          if (out_load) begin
            out_old_q    <= res_old_q;
            out_tframe_q <= res_tframe_q[DIR_W-1:0];
            out_alloc_q  <= res_alloc_q;
            out_oof_q    <= res_oof_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign old_frame_o       = out_old_q;
  assign table_frame_o     = out_tframe_q;
  assign table_allocated_o = out_alloc_q;
  assign out_of_frames_o   = out_oof_q;

  `include "two_level_page_table_updater_macros.svh"

  // Taking a table frame advances the allocator by exactly one.
  `TLPT_ASSERT_NEXT(a_alloc_advance, alloc_take && !cfg_we_i, next_q == NEXT_W'($past(next_q) + 1'b1), "allocator did not advance")
  // An exhausted pool never reports a table, a new table or an old frame.
  `TLPT_ASSERT_IMPL(a_oof_clean, out_valid_o && out_of_frames_o, !table_allocated_o && table_frame_o == '0 && old_frame_o == '0, "exhaustion result not clean")
  // A table entry write only lands in a frame inside the memory.
  `TLPT_ASSERT_IMPL(a_table_write_range, ram_we && (state_q == S_TWR || state_q == S_TRD), tframe_in_range, "table write outside frame memory")

endmodule

`default_nettype wire
